@@ rtl/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and codes for the sample playback mixer: opcodes, status
// codes, register indexes and the sound table entry.
// ----------------------------------------------------------------------------
package spm_pkg;

	// command opcodes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_TRIGGER = 2'd1;
	localparam logic [1:0] OP_WR_BYTE = 2'd2;
	localparam logic [1:0] OP_WR_SND  = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_SOUND = 2'd1;
	localparam logic [1:0] STAT_BAD_CHAN  = 2'd2;

	// register indexes (word address bit 2)
	localparam logic REG_ACTIVE_CH = 1'b0;
	localparam logic REG_SOUND_CNT = 1'b1;

	localparam logic [2:0] ACTIVE_CH_RST = 3'd4;
	localparam logic [4:0] SOUND_CNT_RST = 5'd16;

	// unsigned sample midpoint and ceiling
	localparam logic [7:0] MID_SAMPLE = 8'd128;
	localparam logic [7:0] MAX_SAMPLE = 8'd255;

	typedef struct packed {
		logic [2:0] live_ch;   // active_channels capped at the channel count
		logic [4:0] live_snd;  // sound_count capped at the table depth
	} cfg_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] len;
		logic        rep;
	} snd_entry_t;

endpackage

@@ rtl/spm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// spm_cfg_regs
// APB register block: active channel count and valid sound count, with the
// capped values that the datapath uses.
// ----------------------------------------------------------------------------
module spm_cfg_regs import spm_pkg::*; #(
	parameter int CHANNELS = 4,
	parameter int SOUNDS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	logic [2:0] active_ch_q;
	logic [4:0] sound_cnt_q;
	logic       wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_ch_q <= ACTIVE_CH_RST;
			sound_cnt_q <= SOUND_CNT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ACTIVE_CH: active_ch_q <= pwdata[2:0];
				REG_SOUND_CNT: sound_cnt_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE_CH: prdata = {29'd0, active_ch_q};
			REG_SOUND_CNT: prdata = {27'd0, sound_cnt_q};
			default:       prdata = '0;
		endcase
	end

	// cap at the hardware sizes; the capped value always fits the field
	always_comb begin
		cfg.live_ch  = (32'(active_ch_q) > CHANNELS) ? 3'(CHANNELS) : active_ch_q;
		cfg.live_snd = (32'(sound_cnt_q) > SOUNDS) ? 5'(SOUNDS) : sound_cnt_q;
	end

endmodule

@@ rtl/sample_playback_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// sample_playback_mixer_unit
// Multichannel 8-bit unsigned sample player with a sample store, a sound
// table and per-channel playback state.
// ----------------------------------------------------------------------------
// Each accepted command (start high while busy is low) gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Trigger and write commands give done in the next cycle and busy stays
// low, so a command can be taken every cycle. A tick keeps busy high while
// it walks the capped active channels and then presents its mix; when no
// channel is active, busy stays low and the mix is the midpoint. In the
// channel walk one channel enters per cycle, and each passes one sound
// table read and one sample store read, both registered memories. Sound
// table entries have valid bits and read as zero until written, so there
// is no clearing pass after reset. Sample store bytes hold no defined
// value until written.
// ----------------------------------------------------------------------------
module sample_playback_mixer_unit import spm_pkg::*; #(
	parameter int CHANNELS  = 4,
	parameter int SOUNDS    = 16,
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [1:0]  channel_index,
	input  logic [3:0]  sound_index,
	input  logic [15:0] address,
	input  logic [7:0]  byte_value,
	input  logic [15:0] entry_length,
	input  logic        loop_flag,
	// result channel
	output logic        done,
	output logic [7:0]  mixed_sample,
	output logic        is_sample,
	output logic [1:0]  status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SI_W  = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
	localparam int ACC_W = 9 + $clog2(CHANNELS + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	cfg_t cfg;

	spm_cfg_regs #(
		.CHANNELS (CHANNELS),
		.SOUNDS   (SOUNDS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// memories
	logic [7:0] smp_mem [2**ADDR_BITS];
	snd_entry_t tbl_mem [SOUNDS];
	logic [SOUNDS-1:0] tbl_vld_q;

	// channel state
	logic [CHANNELS-1:0] ch_play_q;
	logic [SI_W-1:0]     ch_snd_q [CHANNELS];
	logic [15:0]         ch_pos_q [CHANNELS];

	// control
	logic            state_q;
	logic            iss_q;
	logic [CH_W-1:0] cnt_q;
	logic            done_q;
	logic            accept;
	logic            last_c;

	// stage 1: channel state and sound table entry
	logic            s1_vld;
	logic            s1_last;
	logic [CH_W-1:0] s1_ch;
	logic            s1_play;
	logic [15:0]     s1_pos;
	logic            s1_tv;
	snd_entry_t      tbl_rd_s1;

	// stage 2: sample byte
	logic       s2_vld;
	logic       s2_last;
	logic       s2_use;
	logic [7:0] smp_rd_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_add;
	logic signed [ACC_W-1:0] acc_nxt;
	logic [7:0]              mix_sat;

	// stage 1 decode
	logic [15:0]          e_start;
	logic [15:0]          e_len;
	logic                 e_rep;
	logic                 s1_over;
	logic                 s1_stop;
	logic [15:0]          s1_p;
	logic [ADDR_BITS-1:0] smp_raddr;
	logic [SI_W-1:0]      tbl_raddr;

	// trigger decode
	logic [1:0]      trig_stat;
	logic [CH_W-1:0] trig_ch;
	logic [SI_W-1:0] snd_widx;
	logic            snd_in_range;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;

	assign last_c    = (32'(cnt_q) + 32'd1 == 32'(cfg.live_ch));
	assign tbl_raddr = ch_snd_q[cnt_q];

	assign trig_ch      = CH_W'(32'(channel_index));
	assign snd_widx     = SI_W'(32'(sound_index));
	assign snd_in_range = (32'(sound_index) < SOUNDS);

	always_comb begin
		if ({1'b0, sound_index} >= cfg.live_snd) begin
			trig_stat = STAT_BAD_SOUND;
		end else if ({1'b0, channel_index} >= cfg.live_ch) begin
			trig_stat = STAT_BAD_CHAN;
		end else begin
			trig_stat = STAT_OK;
		end
	end

	// an unwritten entry reads as zero
	assign e_start = s1_tv ? tbl_rd_s1.start : 16'd0;
	assign e_len   = s1_tv ? tbl_rd_s1.len : 16'd0;
	assign e_rep   = s1_tv ? tbl_rd_s1.rep : 1'b0;

	// past the end: wrap a looping sound of nonzero length, silence anything else
	assign s1_over   = (s1_pos >= e_len);
	assign s1_stop   = s1_over && !(e_rep && (e_len != 16'd0));
	assign s1_p      = s1_over ? 16'd0 : s1_pos;
	assign smp_raddr = ADDR_BITS'(32'(e_start) + 32'(s1_p));

	assign acc_add = s2_use ? ACC_W'($signed({1'b0, smp_rd_s2}) - 10'sd128) : '0;
	assign acc_nxt = acc_q + acc_add;

	always_comb begin
		if (acc_nxt < 0) begin
			mix_sat = 8'd0;
		end else if (acc_nxt > $signed(ACC_W'(MAX_SAMPLE))) begin
			mix_sat = MAX_SAMPLE;
		end else begin
			mix_sat = acc_nxt[7:0];
		end
	end

	// control and reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			iss_q     <= 1'b0;
			cnt_q     <= '0;
			s1_vld    <= 1'b0;
			s2_vld    <= 1'b0;
			done_q    <= 1'b0;
			tbl_vld_q <= '0;
			ch_play_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				ch_snd_q[i] <= '0;
				ch_pos_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			s1_vld <= iss_q;
			s2_vld <= s1_vld;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							OP_TICK: begin
								if (cfg.live_ch == 3'd0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_RUN;
									iss_q   <= 1'b1;
									cnt_q   <= '0;
								end
							end
							OP_TRIGGER: begin
								done_q <= 1'b1;
								if (trig_stat == STAT_OK) begin
									ch_play_q[trig_ch] <= 1'b1;
									ch_snd_q[trig_ch]  <= snd_widx;
									ch_pos_q[trig_ch]  <= 16'd0;
								end
							end
							OP_WR_BYTE: done_q <= 1'b1;
							OP_WR_SND: begin
								done_q <= 1'b1;
								if (snd_in_range) begin
									tbl_vld_q[snd_widx] <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_RUN: begin
					if (iss_q) begin
						if (last_c) begin
							iss_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (s2_vld && s2_last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// write back the channel handled in stage 1
			if (s1_vld && s1_play) begin
				if (s1_stop) begin
					ch_play_q[s1_ch] <= 1'b0;
					ch_pos_q[s1_ch]  <= 16'd0;
				end else begin
					ch_pos_q[s1_ch] <= s1_p + 16'd1;
				end
			end
		end
	end

	// memories, pipeline payload and results
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_WR_BYTE) begin
			smp_mem[ADDR_BITS'(32'(address))] <= byte_value;
		end
		if (accept && opcode == OP_WR_SND && snd_in_range) begin
			tbl_mem[snd_widx] <= '{start: address, len: entry_length, rep: loop_flag};
		end

		tbl_rd_s1 <= tbl_mem[tbl_raddr];
		s1_tv     <= tbl_vld_q[tbl_raddr];
		s1_ch     <= cnt_q;
		s1_last   <= last_c;
		s1_play   <= ch_play_q[cnt_q];
		s1_pos    <= ch_pos_q[cnt_q];

		smp_rd_s2 <= smp_mem[smp_raddr];
		s2_last   <= s1_last;
		s2_use    <= s1_play && !s1_stop;

		if (accept && opcode == OP_TICK) begin
			acc_q <= $signed(ACC_W'(MID_SAMPLE));
		end else if (s2_vld) begin
			acc_q <= acc_nxt;
		end

		if (accept) begin
			mixed_sample <= MID_SAMPLE;
			is_sample    <= (opcode == OP_TICK);
			status       <= (opcode == OP_TRIGGER) ? trig_stat : STAT_OK;
		end else if (s2_vld && s2_last) begin
			mixed_sample <= mix_sat;
			is_sample    <= 1'b1;
			status       <= STAT_OK;
		end
	end

	// checks
	a_walk_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(iss_q || s1_vld || s2_vld) |-> busy)
		else $error("channel walk active while idle");

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_vld && s2_last) |=> (done && is_sample && !busy))
		else $error("tick did not finish after its last channel");

	a_sample_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_sample) |-> (status == STAT_OK))
		else $error("tick result carries an error status");

	a_cmd_midpoint: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_sample) |-> (mixed_sample == MID_SAMPLE))
		else $error("command result not at the midpoint");

endmodule
